### sv/macs_pkg.sv
// Shared types and codes for the moving average crossover signal unit.
package macs_pkg;

  // One input item as it sits in the front queue.
  typedef struct packed {
    logic [31:0] tick_price;
    logic [31:0] tick_time;
    logic        cmd;
  } item_t;

  typedef enum logic {
    CMD_LIVE      = 1'b0,
    CMD_RECOVERED = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MARK_NONE = 2'd0,
    MARK_BUY  = 2'd1,
    MARK_SELL = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXPIRE,
    ST_MUL,
    ST_COMMIT
  } core_state_e;

  // Configuration register indexes (word addresses on the APB port).
  typedef enum logic [1:0] {
    REG_SHORT_WINDOW  = 2'd0,
    REG_LONG_WINDOW   = 2'd1,
    REG_CONFIRM_TICKS = 2'd2,
    REG_MIN_HISTORY   = 2'd3
  } reg_idx_e;

  // Configuration values handed to the back end.
  typedef struct packed {
    logic [15:0] short_window;
    logic [15:0] long_window;
    logic [7:0]  confirm_ticks;
    logic [9:0]  min_history;
  } cfg_t;

  localparam logic [15:0] SHORT_WINDOW_RST  = 16'd360;
  localparam logic [15:0] LONG_WINDOW_RST   = 16'd600;
  localparam logic [7:0]  CONFIRM_TICKS_RST = 8'd100;
  localparam logic [9:0]  MIN_HISTORY_RST   = 10'd500;
  localparam logic [7:0]  RUN_MAX           = 8'd255;

endpackage

### sv/macs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module macs_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/macs_fifo.sv
// Two-entry queue that decouples input acceptance from the processing engine.
module macs_fifo
  import macs_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output item_t out_item_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

endmodule

### sv/macs_core.sv
// Back end: window expiry, average comparison, run tracking and history store.
module macs_core
  import macs_pkg::*;
#(
  parameter int HistoryDepth = 2048,
  parameter int PriceBits    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  item_t       item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_mark_o,
  output logic        out_up_o,
  output logic [31:0] out_price_o,
  output logic        out_overflow_o
);

  localparam int AW = $clog2(HistoryDepth);
  localparam int CW = $clog2(HistoryDepth + 1);
  localparam int SW = PriceBits + CW;
  localparam int PW = SW + 1 + CW;
  localparam logic [CW-1:0] DEPTH_CNT = CW'(HistoryDepth);
  localparam logic [AW-1:0] LAST_SLOT = AW'(HistoryDepth - 1);
  localparam logic [AW-1:0] SLOT_ONE  = AW'(1);
  localparam logic [CW-1:0] CNT_ONE   = CW'(1);

  function automatic logic [AW-1:0] next_slot(logic [AW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + SLOT_ONE;
  endfunction

  core_state_e state_q, state_d;

  logic          cmd_q;
  logic [31:0]   time_q;
  logic [PriceBits-1:0] price_q;

  logic [AW-1:0] wptr_q, wptr_d, stail_q, stail_d, ltail_q, ltail_d;
  logic [SW-1:0] ssum_q, ssum_d, lsum_q, lsum_d;
  logic [CW-1:0] scnt_q, scnt_d, lcnt_q, lcnt_d, hist_q, hist_d;
  logic [7:0]    run_len_q, run_len_d;
  logic          run_up_q, run_up_d;
  logic [PW-1:0] sprod_q, lprod_q;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_mark_q, out_mark_d;
  logic          out_up_q, out_up_d, out_ovf_q, out_ovf_d;
  logic [31:0]   out_price_q, out_price_d;

  logic                 ram_we;
  logic [31:0]          stime_rd, ltime_rd;
  logic [PriceBits-1:0] sprice_rd, lprice_rd;
  logic [63:0]          price_wide;
  logic [63:0]          price_out_wide;
  logic                 load_item;
  logic [SW:0]          sbase, lbase;
  logic [CW-1:0]        scnt_inc, lcnt_inc;

  assign price_wide     = {32'd0, item_i.tick_price};
  assign price_out_wide = 64'(price_q);

  macs_ram #(.Width(32), .Depth(HistoryDepth)) u_stime (
    .clk_i, .we_i(ram_we), .waddr_i(wptr_q), .wdata_i(time_q),
    .raddr_i(stail_q), .rdata_o(stime_rd));
  macs_ram #(.Width(32), .Depth(HistoryDepth)) u_ltime (
    .clk_i, .we_i(ram_we), .waddr_i(wptr_q), .wdata_i(time_q),
    .raddr_i(ltail_q), .rdata_o(ltime_rd));
  macs_ram #(.Width(PriceBits), .Depth(HistoryDepth)) u_sprice (
    .clk_i, .we_i(ram_we), .waddr_i(wptr_q), .wdata_i(price_q),
    .raddr_i(stail_q), .rdata_o(sprice_rd));
  macs_ram #(.Width(PriceBits), .Depth(HistoryDepth)) u_lprice (
    .clk_i, .we_i(ram_we), .waddr_i(wptr_q), .wdata_i(price_q),
    .raddr_i(ltail_q), .rdata_o(lprice_rd));

  logic s_exp, l_exp, s_full, l_full, live, up, mark_ok;

  // A window entry expires when its time plus the window reaches now.
  assign s_exp = (scnt_q != '0) &&
                 ({1'b0, stime_rd} + {17'd0, cfg_i.short_window} <= {1'b0, time_q});
  assign l_exp = (lcnt_q != '0) &&
                 ({1'b0, ltime_rd} + {17'd0, cfg_i.long_window} <= {1'b0, time_q});
  assign s_full = (scnt_q == DEPTH_CNT);
  assign l_full = (lcnt_q == DEPTH_CNT);
  assign live   = (cmd_q == CMD_LIVE);
  assign up     = live && (sprod_q > lprod_q);
  assign mark_ok = (32'(hist_q) > 32'(cfg_i.min_history)) && (cfg_i.confirm_ticks != 8'd0) &&
                   (run_len_q >= cfg_i.confirm_ticks) && (run_up_q == up);

  // Operands of the cross-multiplied comparison.
  assign sbase    = {1'b0, ssum_q} + (SW+1)'(price_q);
  assign lbase    = {1'b0, lsum_q} + (SW+1)'(price_q);
  assign scnt_inc = scnt_q + CNT_ONE;
  assign lcnt_inc = lcnt_q + CNT_ONE;

  assign load_item    = (state_q == ST_IDLE) && item_valid_i;
  assign item_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    wptr_d      = wptr_q;
    stail_d     = stail_q;
    ltail_d     = ltail_q;
    ssum_d      = ssum_q;
    lsum_d      = lsum_q;
    scnt_d      = scnt_q;
    lcnt_d      = lcnt_q;
    hist_d      = hist_q;
    run_len_d   = run_len_q;
    run_up_d    = run_up_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_mark_d  = out_mark_q;
    out_up_d    = out_up_q;
    out_ovf_d   = out_ovf_q;
    out_price_d = out_price_q;
    ram_we      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) state_d = ST_READ;
      end
      ST_READ: state_d = ST_EXPIRE;
      ST_EXPIRE: begin
        if (s_exp) begin
          ssum_d  = ssum_q - SW'(sprice_rd);
          stail_d = next_slot(stail_q);
          scnt_d  = scnt_q - CNT_ONE;
        end
        if (l_exp) begin
          lsum_d  = lsum_q - SW'(lprice_rd);
          ltail_d = next_slot(ltail_q);
          lcnt_d  = lcnt_q - CNT_ONE;
        end
        state_d = (s_exp || l_exp) ? ST_READ : ST_MUL;
      end
      ST_MUL: state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_up_d    = up;
          out_ovf_d   = live && (s_full || l_full);
          out_price_d = price_out_wide[31:0];
          out_mark_d  = MARK_NONE;
          if (live) begin
            if (mark_ok) out_mark_d = up ? MARK_BUY : MARK_SELL;
            if (run_len_q != 8'd0 && run_up_q == up) begin
              if (run_len_q != RUN_MAX) run_len_d = run_len_q + 8'd1;
            end else begin
              run_len_d = 8'd1;
              run_up_d  = up;
            end
          end else begin
            run_len_d = 8'd0;
          end
          // A full window drops its oldest entry, which is the slot overwritten now.
          ssum_d = ssum_q - (s_full ? SW'(sprice_rd) : '0) + SW'(price_q);
          lsum_d = lsum_q - (l_full ? SW'(lprice_rd) : '0) + SW'(price_q);
          if (s_full) stail_d = next_slot(stail_q);
          else        scnt_d  = scnt_inc;
          if (l_full) ltail_d = next_slot(ltail_q);
          else        lcnt_d  = lcnt_inc;
          if (hist_q != DEPTH_CNT) hist_d = hist_q + CNT_ONE;
          ram_we  = 1'b1;
          wptr_d  = next_slot(wptr_q);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      cmd_q   <= item_i.cmd;
      time_q  <= item_i.tick_time;
      price_q <= price_wide[PriceBits-1:0];
    end
    if (state_q == ST_MUL) begin
      sprod_q <= PW'(sbase) * PW'(lcnt_inc);
      lprod_q <= PW'(lbase) * PW'(scnt_inc);
    end
    out_mark_q  <= out_mark_d;
    out_up_q    <= out_up_d;
    out_ovf_q   <= out_ovf_d;
    out_price_q <= out_price_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wptr_q      <= '0;
      stail_q     <= '0;
      ltail_q     <= '0;
      ssum_q      <= '0;
      lsum_q      <= '0;
      scnt_q      <= '0;
      lcnt_q      <= '0;
      hist_q      <= '0;
      run_len_q   <= '0;
      run_up_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wptr_q      <= wptr_d;
      stail_q     <= stail_d;
      ltail_q     <= ltail_d;
      ssum_q      <= ssum_d;
      lsum_q      <= lsum_d;
      scnt_q      <= scnt_d;
      lcnt_q      <= lcnt_d;
      hist_q      <= hist_d;
      run_len_q   <= run_len_d;
      run_up_q    <= run_up_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_mark_o     = out_mark_q;
  assign out_up_o       = out_up_q;
  assign out_price_o    = out_price_q;
  assign out_overflow_o = out_ovf_q;

endmodule

### sv/moving_average_crossover_signal_unit.sv
// Top level of the moving average crossover signal unit.
//
// Each tick transaction carries a timestamp and a price and yields exactly one
// result transaction. A two-entry queue accepts ticks while the back end works,
// and the result register lets a new tick enter while a result waits. The back
// end handles one tick at a time: after it takes a tick from the queue it passes
// through the read, expiry check, multiply and commit states when no history
// entry leaves a window, and it returns to idle before it takes the next tick.
// Each expiry step, in which either window or both retire their oldest entry,
// adds a further read and expiry check, since every step needs one registered
// read of the history RAMs at the window tails. A waiting result holds the commit state.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8 and 12
// and are to be written only while no tick is in flight. History RAM contents
// are not cleared at reset; only entries already written are ever used.
module moving_average_crossover_signal_unit
  import macs_pkg::*;
#(
  parameter int HISTORY_DEPTH = 2048,
  parameter int PRICE_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] tick_time, [63:32] tick_price
  input  logic        s_axis_tuser,   // [0] cmd
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] order_price
  output logic [3:0]  m_axis_tuser,   // [1:0] tick_mark, [2] trend_up, [3] window_overflow
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg_q;
  item_t in_item, q_item;
  logic  q_valid, q_ready;
  logic  cfg_we;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_window  <= SHORT_WINDOW_RST;
      cfg_q.long_window   <= LONG_WINDOW_RST;
      cfg_q.confirm_ticks <= CONFIRM_TICKS_RST;
      cfg_q.min_history   <= MIN_HISTORY_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SHORT_WINDOW:  cfg_q.short_window  <= pwdata[15:0];
        REG_LONG_WINDOW:   cfg_q.long_window   <= pwdata[15:0];
        REG_CONFIRM_TICKS: cfg_q.confirm_ticks <= pwdata[7:0];
        REG_MIN_HISTORY:   cfg_q.min_history   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHORT_WINDOW:  prdata = {16'd0, cfg_q.short_window};
      REG_LONG_WINDOW:   prdata = {16'd0, cfg_q.long_window};
      REG_CONFIRM_TICKS: prdata = {24'd0, cfg_q.confirm_ticks};
      REG_MIN_HISTORY:   prdata = {22'd0, cfg_q.min_history};
      default:           prdata = 32'd0;
    endcase
  end

  assign in_item.cmd        = s_axis_tuser;
  assign in_item.tick_time  = s_axis_tdata[31:0];
  assign in_item.tick_price = s_axis_tdata[63:32];

  // Front end: accepts tick transactions into a short queue.
  macs_fifo u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  // Back end: window bookkeeping, comparison and result register.
  macs_core #(.HistoryDepth(HISTORY_DEPTH), .PriceBits(PRICE_BITS)) u_core (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .item_valid_i(q_valid), .item_ready_o(q_ready), .item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_mark_o(m_axis_tuser[1:0]), .out_up_o(m_axis_tuser[2]),
    .out_price_o(m_axis_tdata), .out_overflow_o(m_axis_tuser[3])
  );

endmodule
